### hdl/sslpd_pkg.sv
`default_nettype none
package sslpd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int RATE_W      = 12;
  localparam int TRIM_W      = 8;
  localparam int ANGLE_W     = 8;
  localparam int TIME_W      = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLED     = 2'd0,
    REG_SLEW_RATE   = 2'd1,
    REG_TRIM_OFFSET = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                     enabled;
    logic [RATE_W-1:0]        slew_rate;
    logic signed [TRIM_W-1:0] trim_offset;
  } cfg_t;

  // Saturated elapsed * rate product, held non-negative
  localparam int PSAT_W = 31;
  // Widest step: (2^31-1)/1000 needs 22 bits
  localparam int STEP_W = 22;

  // floor(p/1000) = floor((p>>3)/125) = ((p>>3) * DIV125_M) >> DIV125_SHIFT for p < 2^31
  localparam int              DIV125_M_W   = 29;
  localparam logic [28:0]     DIV125_M     = 29'd274877907;
  localparam int              DIV125_SHIFT = 35;

  // floor(n/7200) = floor((n>>5)/225) = ((n>>5) * DIV225_M) >> DIV225_SHIFT for n>>5 < 2^21
  localparam int              DIV225_M_W   = 22;
  localparam logic [21:0]     DIV225_M     = 22'd2386093;
  localparam int              DIV225_SHIFT = 29;
  localparam int              DUTY_PRE_SHIFT = 5;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd180;
  localparam logic [9:0]         ANGLE_BIAS    = 10'd180;
  localparam int                 HOME_POSITION = 90;

endpackage
`default_nettype wire

### hdl/sslpd_cmd_if.sv
`default_nettype none
interface sslpd_cmd_if
  import sslpd_pkg::*;
#(
  parameter int POSITION_BITS = 11
);
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] target_position;
  logic [TIME_W-1:0]               time_ms;

  modport source (output valid, output target_position, output time_ms, input ready);
  modport sink   (input valid, input target_position, input time_ms, output ready);
endinterface
`default_nettype wire

### hdl/sslpd_res_if.sv
`default_nettype none
interface sslpd_res_if
  import sslpd_pkg::*;
#(
  parameter int DUTY_BITS = 13
);
  logic                 valid;
  logic                 ready;
  logic [ANGLE_W-1:0]   clamped_angle;
  logic [DUTY_BITS-1:0] pwm_duty;

  modport source (output valid, output clamped_angle, output pwm_duty, input ready);
  modport sink   (input valid, input clamped_angle, input pwm_duty, output ready);
endinterface
`default_nettype wire

### hdl/servo_slew_limited_pwm_duty_core.sv
`default_nettype none
// Slew-limited servo position to 50 Hz PWM duty. Each command item carries a
// target angle in degrees and a free-running millisecond timestamp; the core
// moves its kept position toward the target by at most max(1, elapsed*rate/1000)
// degrees (saturated product, any rate of zero jumps straight there), adds the
// trim, clamps to 0..180 and turns the angle into a duty count of
// floor((4*angle+180)*(2^DUTY_BITS-1)/7200). Commands taken while disabled are
// dropped without a result and leave the state alone. One item is accepted per
// clock unless the output stalls with every stage full; each result passes the
// capture, product, step, kept-position and duty registers in turn, the rate
// set by the kept-position register, which updates once per item. Bubbles are
// filled, so commands keep flowing while a registered result waits to be taken.
// Write configuration only while no command is in flight.
module servo_slew_limited_pwm_duty_core
  import sslpd_pkg::*;
#(
  parameter int DUTY_BITS     = 13,
  parameter int POSITION_BITS = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  sslpd_cmd_if.sink                   cmd,
  sslpd_res_if.source                 res
);

  cfg_t cfg;

  // Step stage to tracker
  logic                            step_valid;
  logic                            step_ready;
  logic signed [POSITION_BITS-1:0] step_target;
  logic [STEP_W-1:0]               step_size;

  // Tracker to duty conversion
  logic                            ang_valid;
  logic                            ang_ready;
  logic [ANGLE_W-1:0]              ang_value;

  // Configuration registers, written from the plain write port
  sslpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Capture, elapsed time, saturated product and step size
  sslpd_step_calc #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (cmd.valid),
    .in_ready   (cmd.ready),
    .in_target  (cmd.target_position),
    .in_time    (cmd.time_ms),
    .out_valid  (step_valid),
    .out_ready  (step_ready),
    .out_target (step_target),
    .out_step   (step_size)
  );

  // Advance the kept position, add trim and clamp
  sslpd_slew_track #(
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (step_valid),
    .in_ready  (step_ready),
    .in_target (step_target),
    .in_step   (step_size),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_angle (ang_value)
  );

  // Angle to duty count, into the result register
  sslpd_duty_conv #(
    .DUTY_BITS (DUTY_BITS)
  ) u_duty (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_angle  (ang_value),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_angle (res.clamped_angle),
    .out_duty  (res.pwm_duty)
  );

endmodule
`default_nettype wire

### hdl/sslpd_cfg_regs.sv
`default_nettype none
module sslpd_cfg_regs
  import sslpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_ENABLED:     cfg.enabled     <= wr_data[0];
        REG_SLEW_RATE:   cfg.slew_rate   <= wr_data[RATE_W-1:0];
        REG_TRIM_OFFSET: cfg.trim_offset <= $signed(wr_data[TRIM_W-1:0]);
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/sslpd_step_calc.sv
`default_nettype none
module sslpd_step_calc
  import sslpd_pkg::*;
#(
  parameter int POSITION_BITS = 11
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cfg_t                            cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [POSITION_BITS-1:0] in_target,
  input  wire logic [TIME_W-1:0]               in_time,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [POSITION_BITS-1:0]      out_target,
  output logic [STEP_W-1:0]                    out_step
);

  localparam int PROD_W = TIME_W + RATE_W + 1;
  localparam int M_W    = PSAT_W - 3;
  localparam int QP_W   = M_W + DIV125_M_W;

  logic [TIME_W-1:0]               last_time;
  logic                            v1, v2, v3;
  logic                            ld1, ld2, ld3;
  logic signed [POSITION_BITS-1:0] target1, target2;
  logic signed [TIME_W-1:0]        elapsed1;
  logic [PSAT_W-1:0]               psat2;
  logic signed [PROD_W-1:0]        prod;
  logic [PSAT_W-1:0]               psat_next;
  logic [QP_W-1:0]                 qprod;
  logic [STEP_W-1:0]               quot;
  logic [STEP_W-1:0]               step_next;

  assign ld3      = !v3 || out_ready;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  // Saturate the product into [0, 2^31-1]; non-positive gives zero
  assign prod = PROD_W'(elapsed1) * PROD_W'($signed({1'b0, cfg.slew_rate}));

  always_comb begin
    if (prod[PROD_W-1]) begin
      psat_next = '0;
    end else if (|prod[PROD_W-2:PSAT_W]) begin
      psat_next = '1;
    end else begin
      psat_next = prod[PSAT_W-1:0];
    end
  end

  assign qprod     = QP_W'(psat2[PSAT_W-1:3]) * QP_W'(DIV125_M);
  assign quot      = qprod[DIV125_SHIFT +: STEP_W];
  assign step_next = (quot == '0) ? STEP_W'(1) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      last_time <= '0;
    end else begin
      if (ld1) v1 <= in_valid && cfg.enabled;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (in_valid && ld1 && cfg.enabled) last_time <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      target1  <= in_target;
      elapsed1 <= $signed(in_time - last_time);
    end
    if (ld2) begin
      target2 <= target1;
      psat2   <= psat_next;
    end
    if (ld3) begin
      out_target <= target2;
      out_step   <= step_next;
    end
  end

  assign out_valid = v3;

endmodule
`default_nettype wire

### hdl/sslpd_slew_track.sv
`default_nettype none
module sslpd_slew_track
  import sslpd_pkg::*;
#(
  parameter int POSITION_BITS = 11
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cfg_t                            cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [POSITION_BITS-1:0] in_target,
  input  wire logic [STEP_W-1:0]               in_step,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ANGLE_W-1:0]                   out_angle
);

  localparam int PW = POSITION_BITS;

  logic signed [PW-1:0] cur;
  logic signed [PW-1:0] cur_next;
  logic                 v4;
  logic                 ld4;
  logic signed [PW:0]   diff;
  logic [PW:0]          gap;
  logic [PW:0]          moved;
  logic signed [PW:0]   sum;
  logic [ANGLE_W-1:0]   angle_next;

  assign ld4      = !v4 || out_ready;
  assign in_ready = ld4;

  assign diff = {in_target[PW-1], in_target} - {cur[PW-1], cur};
  assign gap  = diff[PW] ? (PW+1)'(-diff) : diff;

  // Step is below the gap here, so it fits the position width
  always_comb begin
    if (diff[PW]) begin
      moved = {cur[PW-1], cur} - {1'b0, in_step[PW-1:0]};
    end else begin
      moved = {cur[PW-1], cur} + {1'b0, in_step[PW-1:0]};
    end
  end

  always_comb begin
    if ((cfg.slew_rate == '0) || (STEP_W'(gap) <= in_step)) begin
      cur_next = in_target;
    end else begin
      cur_next = moved[PW-1:0];
    end
  end

  assign sum = {cur_next[PW-1], cur_next} + (PW+1)'(cfg.trim_offset);

  always_comb begin
    if (sum[PW]) begin
      angle_next = '0;
    end else if (sum[PW-1:0] > PW'(ANGLE_MAX)) begin
      angle_next = ANGLE_MAX;
    end else begin
      angle_next = sum[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4  <= 1'b0;
      cur <= PW'(HOME_POSITION);
    end else begin
      if (ld4) v4 <= in_valid;
      if (in_valid && ld4) cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ld4) out_angle <= angle_next;
  end

  assign out_valid = v4;

endmodule
`default_nettype wire

### hdl/sslpd_duty_conv.sv
`default_nettype none
module sslpd_duty_conv
  import sslpd_pkg::*;
#(
  parameter int DUTY_BITS = 13
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [ANGLE_W-1:0] in_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ANGLE_W-1:0]      out_angle,
  output logic [DUTY_BITS-1:0]    out_duty
);

  localparam int N_W  = DUTY_BITS + 10;
  localparam int M_W  = N_W - DUTY_PRE_SHIFT;
  // Wide enough for the product and for the quotient field above the shift
  localparam int QP_W = DIV225_SHIFT + DUTY_BITS;

  logic                 v5;
  logic                 ld5;
  logic [9:0]           pulse;
  logic [N_W-1:0]       scaled;
  logic [QP_W-1:0]      qprod;

  assign ld5      = !v5 || out_ready;
  assign in_ready = ld5;

  // (4*angle + 180) * (2^DUTY_BITS - 1) as shift and subtract, then divide by 7200
  assign pulse  = {in_angle, 2'b00} + ANGLE_BIAS;
  assign scaled = (N_W'(pulse) << DUTY_BITS) - N_W'(pulse);
  assign qprod  = QP_W'(scaled[N_W-1:DUTY_PRE_SHIFT]) * QP_W'(DIV225_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (ld5) begin
      v5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ld5) begin
      out_angle <= in_angle;
      out_duty  <= qprod[DIV225_SHIFT +: DUTY_BITS];
    end
  end

  assign out_valid = v5;

endmodule
`default_nettype wire
